// ----- rtl/vrwd_pkg.sv -----
// ----------------------------------------------------------------------------
// VME readout word decoder package
// Shared types, codes and default sizes for the readout word decoder blocks.
// ----------------------------------------------------------------------------
package vrwd_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MAX_HITS_DEF     = 10;
  localparam int unsigned TDC_CHANNELS_DEF = 32;
  localparam int unsigned STAMP_WORDS_DEF  = 5;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  // Fixed field values of the readout formats.
  localparam logic [4:0]  STAMP_MODULE  = 5'd20;
  localparam logic [4:0]  GEO_TDC_HIT   = 5'd0;
  localparam logic [4:0]  GEO_TDC_HDR   = 5'd8;
  localparam logic [4:0]  GEO_TDC_TRL   = 5'd16;
  localparam logic [2:0]  HDR_TYPE_DATA = 3'd2;
  localparam logic [14:0] MIN_SUB_LEN   = 15'd2;
  localparam logic [14:0] WC_MAX        = 15'h7FFF;

  // Sub-event kind selected on the input.
  typedef enum logic [2:0] {
    OP_STD    = 3'd0,
    OP_STAMP  = 3'd1,
    OP_USER   = 3'd2,
    OP_LEGACY = 3'd3
  } op_t;

  // Kind of a result record.
  typedef enum logic [2:0] {
    KIND_CRATE0    = 3'd0,
    KIND_CRATE1    = 3'd1,
    KIND_SCALER    = 3'd2,
    KIND_TDC_HIT   = 3'd3,
    KIND_TDC_CLEAR = 3'd4,
    KIND_LEN_ERR   = 3'd5
  } kind_t;

  // Parser phase of the front end.
  typedef enum logic [3:0] {
    PH_HDR        = 4'd0,
    PH_DATA       = 4'd1,
    PH_END        = 4'd2,
    PH_LEGACY     = 4'd3,
    PH_RAW        = 4'd4,
    PH_STAMP      = 4'd5,
    PH_SCALER     = 4'd6,
    PH_SCALER_END = 4'd7,
    PH_TDC_CHECK  = 4'd8,
    PH_HITS       = 4'd9,
    PH_DONE       = 4'd10
  } phase_t;

  // One result record.
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  module_res;
    logic [5:0]  channel;
    logic [3:0]  hit_index;
    logic [31:0] value;
  } rec_t;

  // One queue entry: the records caused by one word (one or two).
  typedef struct packed {
    logic two;
    rec_t rec0;
    rec_t rec1;
  } entry_t;

endpackage

// ----- rtl/vrwd_front.sv -----
// ----------------------------------------------------------------------------
// Readout word parser
// Accepts one readout word per beat while the record queue has room, tracks
// the sub-event format and queues the one or two records the word causes.
// ----------------------------------------------------------------------------
module vrwd_front #(
  parameter int unsigned MAX_HITS     = vrwd_pkg::MAX_HITS_DEF,
  parameter int unsigned TDC_CHANNELS = vrwd_pkg::TDC_CHANNELS_DEF,
  parameter int unsigned STAMP_WORDS  = vrwd_pkg::STAMP_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [31:0]      in_word,
  input  logic             in_first,
  input  logic [14:0]      in_sub_length,
  output logic             push,
  output vrwd_pkg::entry_t push_data,
  input  logic             q_full
);
  import vrwd_pkg::*;

  localparam int unsigned HC_IDX_W = (TDC_CHANNELS > 1) ? $clog2(TDC_CHANNELS) : 1;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [5:0]  words_left_r, words_left_nxt;
  logic [5:0]  item_index_r, item_index_nxt;
  logic [4:0]  block_module_r, block_module_nxt;
  logic [14:0] word_count_r, word_count_nxt;
  logic        length_bad_r, length_bad_nxt;
  logic [3:0]  hit_cnt_r [TDC_CHANNELS];

  // State as seen by this word after a sub-event start is applied.
  phase_t      eff_ph;
  logic [5:0]  eff_wl;
  logic [5:0]  eff_ii;
  logic [14:0] eff_wc;
  logic        eff_lb;
  logic        len_err;

  // Word fields and decisions.
  op_t           op;
  logic          accept;
  logic [4:0]    geo;
  logic [2:0]    hdr_type;
  logic [5:0]    std_nlw;
  logic [5:0]    usr_nlw;
  logic          std_take;
  logic          usr_take;
  logic          len_done;
  logic [5:0]    wl_dec;
  logic [5:0]    ii_inc;
  logic [4:0]    tdc_ch;
  logic [20:0]   tdc_val;
  logic [HC_IDX_W-1:0] hc_idx;
  logic          ch_in_range;
  logic [3:0]    hc_rd;
  logic          hit_ok;
  logic          hc_clr;
  logic          hc_inc;
  logic          go_tdc_after;
  logic          go_usr_hdr;
  logic          emit0;
  logic          emit1;
  rec_t          rec0;
  rec_t          rec1;

  assign op       = op_t'(in_op);
  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  assign geo      = in_word[31:27];
  assign hdr_type = in_word[26:24];
  assign std_nlw  = in_word[5:0];
  assign usr_nlw  = in_word[13:8];
  assign std_take = (hdr_type == HDR_TYPE_DATA) && (std_nlw != 6'd0);
  assign usr_take = (hdr_type == HDR_TYPE_DATA) && (usr_nlw != 6'd0);
  assign len_done = (eff_wc >= in_sub_length);
  assign wl_dec   = eff_wl - 6'd1;
  assign ii_inc   = eff_ii + 6'd1;

  // TDC hit fields and the hit counter of the addressed channel.
  assign tdc_ch      = in_word[25:21];
  assign tdc_val     = in_word[20:0];
  assign hc_idx      = tdc_ch[HC_IDX_W-1:0];
  assign ch_in_range = ({1'b0, tdc_ch} < 6'(TDC_CHANNELS));

  always_comb begin
    hc_rd = 4'd0;
    if (ch_in_range) begin
      hc_rd = hit_cnt_r[hc_idx];
    end
  end

  assign hit_ok = (geo == GEO_TDC_HIT) && ch_in_range && (hc_rd < 4'(MAX_HITS)) &&
                  (tdc_val != 21'd0);

  // Sub-event start: restart the counters and pick the format.
  always_comb begin
    eff_ph  = phase_r;
    eff_wl  = words_left_r;
    eff_ii  = item_index_r;
    eff_wc  = word_count_r;
    eff_lb  = length_bad_r;
    len_err = 1'b0;
    if (in_first) begin
      eff_wl = 6'd0;
      eff_ii = 6'd0;
      eff_wc = 15'd0;
      eff_lb = 1'b0;
      unique case (op) inside
        OP_STD: begin
          eff_ph = PH_HDR;
        end
        OP_LEGACY: begin
          eff_ph = PH_LEGACY;
        end
        OP_STAMP, OP_USER: begin
          if (in_sub_length < MIN_SUB_LEN) begin
            len_err = 1'b1;
            eff_lb  = 1'b1;
            eff_ph  = PH_DONE;
          end else if (op == OP_STAMP) begin
            eff_ph = PH_STAMP;
          end else begin
            eff_ph = PH_HDR;
          end
        end
        default: begin
          eff_ph = PH_DONE;
        end
      endcase
    end
  end

  // Next state of the parser.
  always_comb begin
    phase_nxt        = eff_ph;
    words_left_nxt   = eff_wl;
    item_index_nxt   = eff_ii;
    block_module_nxt = block_module_r;
    length_bad_nxt   = eff_lb;
    word_count_nxt   = (eff_wc != WC_MAX) ? eff_wc + 15'd1 : eff_wc;
    go_tdc_after     = 1'b0;
    go_usr_hdr       = 1'b0;
    unique case (eff_ph)
      PH_HDR: begin
        unique case (op) inside
          OP_STD, OP_LEGACY: begin
            if (len_done) begin
              phase_nxt = PH_DONE;
            end else if (std_take) begin
              words_left_nxt = std_nlw;
              item_index_nxt = 6'd0;
              phase_nxt      = PH_DATA;
            end else begin
              phase_nxt = PH_HDR;
            end
          end
          OP_USER: begin
            go_usr_hdr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      PH_DATA: begin
        words_left_nxt = wl_dec;
        if (wl_dec == 6'd0) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        phase_nxt = PH_HDR;
      end
      PH_LEGACY: begin
        words_left_nxt   = std_nlw;
        block_module_nxt = geo;
        item_index_nxt   = 6'd0;
        phase_nxt        = (std_nlw != 6'd0) ? PH_RAW : PH_HDR;
      end
      PH_RAW: begin
        item_index_nxt = ii_inc;
        words_left_nxt = wl_dec;
        if (wl_dec == 6'd0) begin
          phase_nxt = PH_END;
        end
      end
      PH_STAMP: begin
        if (eff_wc >= 15'(STAMP_WORDS)) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SCALER: begin
        item_index_nxt = ii_inc;
        words_left_nxt = wl_dec;
        if (wl_dec == 6'd0) begin
          phase_nxt = PH_SCALER_END;
        end
      end
      PH_SCALER_END: begin
        phase_nxt = PH_TDC_CHECK;
      end
      PH_TDC_CHECK: begin
        if (geo == GEO_TDC_HDR) begin
          phase_nxt = PH_HITS;
        end else begin
          go_tdc_after = 1'b1;
        end
      end
      PH_HITS: begin
        if (geo != GEO_TDC_HIT) begin
          go_tdc_after = 1'b1;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // A word that ends a TDC block is either its trailer or a new user header.
    if (go_tdc_after) begin
      if ((geo == GEO_TDC_TRL) && !len_done) begin
        phase_nxt = PH_HDR;
      end else begin
        go_usr_hdr = 1'b1;
      end
    end

    // User crate header: done, scaler block, or straight to the TDC block check.
    if (go_usr_hdr) begin
      if (len_done) begin
        phase_nxt = PH_DONE;
      end else if (usr_take) begin
        words_left_nxt   = usr_nlw;
        item_index_nxt   = 6'd0;
        block_module_nxt = geo;
        phase_nxt        = PH_SCALER;
      end else begin
        phase_nxt = PH_TDC_CHECK;
      end
    end
  end

  // Records caused by this word.
  always_comb begin
    emit0 = 1'b0;
    emit1 = 1'b0;
    rec0  = '{kind: KIND_CRATE0, module_res: 5'd0, channel: 6'd0, hit_index: 4'd0,
              value: 32'd0};
    rec1  = rec0;
    if (len_err) begin
      emit0     = 1'b1;
      rec0.kind = KIND_LEN_ERR;
    end else begin
      unique case (eff_ph)
        PH_DATA: begin
          emit0           = 1'b1;
          rec0.kind       = (op == OP_LEGACY) ? KIND_CRATE1 : KIND_CRATE0;
          rec0.module_res = geo;
          rec0.channel    = {1'b0, in_word[20:16]};
          rec0.value      = {16'd0, in_word[15:0]};
        end
        PH_RAW: begin
          emit0           = 1'b1;
          rec0.kind       = KIND_CRATE1;
          rec0.module_res = block_module_r;
          rec0.channel    = eff_ii;
          rec0.value      = in_word;
        end
        PH_STAMP: begin
          if (eff_wc < 15'(STAMP_WORDS)) begin
            emit0           = 1'b1;
            emit1           = 1'b1;
            rec0.kind       = KIND_CRATE0;
            rec0.module_res = STAMP_MODULE;
            rec0.channel    = {eff_wc[4:0], 1'b0};
            rec0.value      = {16'd0, in_word[15:0]};
            rec1.kind       = KIND_CRATE0;
            rec1.module_res = STAMP_MODULE;
            rec1.channel    = {eff_wc[4:0], 1'b1};
            rec1.value      = {16'd0, in_word[31:16]};
          end
        end
        PH_SCALER: begin
          emit0        = 1'b1;
          rec0.kind    = KIND_SCALER;
          rec0.channel = eff_ii;
          rec0.value   = in_word;
        end
        PH_TDC_CHECK: begin
          emit0     = 1'b1;
          rec0.kind = KIND_TDC_CLEAR;
        end
        PH_HITS: begin
          if (hit_ok) begin
            emit0          = 1'b1;
            rec0.kind      = KIND_TDC_HIT;
            rec0.channel   = {1'b0, tdc_ch};
            rec0.hit_index = hc_rd;
            rec0.value     = {11'd0, tdc_val};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push      = accept && emit0;
  assign push_data = '{two: emit1, rec0: rec0, rec1: rec1};

  assign hc_clr = accept && (eff_ph == PH_TDC_CHECK) && !len_err;
  assign hc_inc = accept && (eff_ph == PH_HITS) && hit_ok;

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR;
      words_left_r   <= 6'd0;
      item_index_r   <= 6'd0;
      block_module_r <= 5'd0;
      word_count_r   <= 15'd0;
      length_bad_r   <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      words_left_r   <= words_left_nxt;
      item_index_r   <= item_index_nxt;
      block_module_r <= block_module_nxt;
      word_count_r   <= word_count_nxt;
      length_bad_r   <= length_bad_nxt;
    end
  end

  // Per-channel hit counters, cleared together at each TDC block.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TDC_CHANNELS; i++) begin
      if (!rst_n || hc_clr) begin
        hit_cnt_r[i] <= 4'd0;
      end else if (hc_inc && (hc_idx == HC_IDX_W'(i))) begin
        hit_cnt_r[i] <= hit_cnt_r[i] + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  // A short sub-event leaves the parser idle until the next first word.
  a_len_bad_done: assert property (@(posedge clk) disable iff (!rst_n)
    length_bad_r |-> (phase_r == PH_DONE))
    else $error("length error flag set outside the done phase");

  // Counted phases always have words left to take.
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DATA) || (phase_r == PH_RAW) || (phase_r == PH_SCALER)) |->
      (words_left_r != 6'd0))
    else $error("counted phase entered with no words left");
`endif

endmodule

// ----- rtl/vrwd_queue.sv -----
// ----------------------------------------------------------------------------
// Record queue
// Short queue of record entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module vrwd_queue #(
  parameter int unsigned DEPTH = vrwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vrwd_pkg::entry_t push_data,
  output logic             full,
  output logic             q_valid,
  output vrwd_pkg::entry_t q_data,
  input  logic             q_pop
);
  import vrwd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = entry_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || q_pop))
    else $error("record queue written while full");

  // The output stage only takes an entry that is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("record queue read while empty");
`endif

endmodule

// ----- rtl/vrwd_back.sv -----
// ----------------------------------------------------------------------------
// Record output stage
// Takes queue entries and sends their records one beat at a time through
// an output register, marking the last record of each word.
// ----------------------------------------------------------------------------
module vrwd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  vrwd_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output logic [4:0]       out_module_res,
  output logic [5:0]       out_channel,
  output logic [3:0]       out_hit_index,
  output logic [31:0]      out_value,
  output logic             out_last_of_run
);
  import vrwd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic sel_r, sel_nxt;
  rec_t out_rec_r;
  logic out_last_r;
  logic load_ok;
  logic load;
  rec_t cur_rec;
  logic cur_last;

  // The output register can take a new record when empty or being drained.
  assign load_ok  = !out_valid_r || !out_stall;
  assign load     = load_ok && q_valid;
  assign cur_rec  = sel_r ? q_data.rec1 : q_data.rec0;
  assign cur_last = sel_r || !q_data.two;
  assign q_pop    = load && cur_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    if (load_ok) begin
      out_valid_nxt = q_valid;
    end
    if (load) begin
      sel_nxt = !cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r  <= cur_rec;
      out_last_r <= cur_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_rec_r.kind;
  assign out_module_res  = out_rec_r.module_res;
  assign out_channel     = out_rec_r.channel;
  assign out_hit_index   = out_rec_r.hit_index;
  assign out_value       = out_rec_r.value;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  // While the second record of a word is pending its entry stays at the head.
  a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (q_valid && q_data.two))
    else $error("second record pending without a two-record entry");
`endif

endmodule

// ----- rtl/vme_readout_word_decoder_top.sv -----
// ----------------------------------------------------------------------------
// VME readout word decoder
// Parses a stream of 32-bit readout words and emits decoded store records.
// ----------------------------------------------------------------------------
// The decoder accepts one readout word per clock cycle and holds no stall of
// its own as long as the record queue has room. Each word yields zero, one or
// two records; a record is written into the record queue and then into the
// output register before it leaves. The single output register sends one
// record per cycle while out_stall is low, so timestamp words, which give two
// records each, stall the input once the QUEUE_DEPTH-entry record queue has
// filled. The TDC hit counters are flip-flops cleared by reset, so the block
// is ready as soon as reset is released, with no clearing pass.
module vme_readout_word_decoder_top #(
  parameter int unsigned MAX_HITS     = vrwd_pkg::MAX_HITS_DEF,
  parameter int unsigned TDC_CHANNELS = vrwd_pkg::TDC_CHANNELS_DEF,
  parameter int unsigned STAMP_WORDS  = vrwd_pkg::STAMP_WORDS_DEF,
  parameter int unsigned QUEUE_DEPTH  = vrwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_word,
  input  logic        in_first,
  input  logic [14:0] in_sub_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_module_res,
  output logic [5:0]  out_channel,
  output logic [3:0]  out_hit_index,
  output logic [31:0] out_value,
  output logic        out_last_of_run
);
  import vrwd_pkg::*;

  logic   push;
  entry_t push_data;
  logic   q_full;
  logic   q_valid;
  entry_t q_data;
  logic   q_pop;

  // Parser front end.
  vrwd_front #(
    .MAX_HITS     (MAX_HITS),
    .TDC_CHANNELS (TDC_CHANNELS),
    .STAMP_WORDS  (STAMP_WORDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_word       (in_word),
    .in_first      (in_first),
    .in_sub_length (in_sub_length),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  // Record queue.
  vrwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  // Output stage.
  vrwd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_module_res  (out_module_res),
    .out_channel     (out_channel),
    .out_hit_index   (out_hit_index),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule
